### src/pgf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgf_pkg
// Shared types, latencies and arithmetic helpers of the pairwise gravity
// force pipeline. Values travel as unsigned m * 2^e with a normalised 32-bit
// mantissa; a zero mantissa stands for zero.
// ----------------------------------------------------------------------------
package pgf_pkg;

  typedef logic signed [15:0] pgf_exp_t;

  typedef struct packed {
    logic [31:0] m;
    pgf_exp_t    e;
  } xnum_t;

  // payload of one item on the input bus, last field (first_x) in the lowest bits
  typedef struct packed {
    logic [47:0] second_mass;
    logic [47:0] second_z;
    logic [47:0] second_y;
    logic [47:0] second_x;
    logic [47:0] first_mass;
    logic [47:0] first_z;
    logic [47:0] first_y;
    logic [47:0] first_x;
  } in_t;

  // what the front end hands on: r^2, axis magnitudes, signs and masses
  typedef struct packed {
    xnum_t         s;
    xnum_t [2:0]   magn;
    logic  [2:0]   dneg;
    xnum_t         m1n;
    xnum_t         m2n;
  } front_t;

  // pipeline depths of the units
  localparam int unsigned LatFront   = 6;
  localparam int unsigned SqrtSteps  = 4;
  localparam int unsigned SqrtStages = 32 / SqrtSteps;
  localparam int unsigned LogStages  = 32;
  localparam int unsigned PowStages  = 32;
  localparam int unsigned LatPow     = LogStages + 1 + PowStages;
  localparam int unsigned DivSteps   = 3;
  localparam int unsigned DivStages  = 33 / DivSteps;

  // 4*pi^2
  localparam xnum_t FourPiSq = '{m: 32'd2649351758, e: -16'sd26};

  // floor square root, used at elaboration to build the root table
  function automatic logic [31:0] pgf_isqrt64(logic [63:0] v);
    logic [34:0] rem;
    logic [34:0] t;
    logic [31:0] q;
    rem = '0;
    q   = '0;
    for (int i = 31; i >= 0; i--) begin
      rem = {rem[32:0], v[2*i+1], v[2*i]};
      t   = {1'b0, q, 2'b01};
      if (rem >= t) begin
        rem = rem - t;
        q   = {q[30:0], 1'b1};
      end else begin
        q   = {q[30:0], 1'b0};
      end
    end
    return q;
  endfunction

  // 2^(2^-n) in Q1.31, by n repeated truncated square roots of 2
  function automatic logic [31:0] pgf_root(int unsigned n);
    logic [63:0] c;
    c = 64'h1_0000_0000;
    for (int unsigned i = 0; i < n; i++) begin
      c = {32'b0, pgf_isqrt64(c << 31)};
    end
    return c[31:0];
  endfunction

  // position of the leading one
  function automatic logic [6:0] pgf_msb(logic [97:0] v);
    logic [6:0] p;
    p = '0;
    for (int i = 0; i < 98; i++) begin
      if (v[i]) p = 7'(i);
    end
    return p;
  endfunction

  // truncate a wide value to the mantissa format, given its leading one
  function automatic xnum_t pgf_norm(logic [97:0] v, logic [6:0] pos, pgf_exp_t base);
    xnum_t       r;
    logic [97:0] sh;
    r  = '0;
    sh = (pos >= 7'd31) ? (v >> (pos - 7'd31)) : (v << (7'd31 - pos));
    if (v != '0) begin
      r.m = sh[31:0];
      r.e = base + pgf_exp_t'({9'b0, pos}) - 16'sd31;
    end
    return r;
  endfunction

  // truncated product of two normalised values
  function automatic xnum_t pgf_mul(xnum_t a, xnum_t b);
    xnum_t       r;
    logic [63:0] p;
    r = '0;
    p = 64'(a.m) * 64'(b.m);
    if (a.m != '0 && b.m != '0) begin
      if (p[63]) begin
        r.m = p[63:32];
        r.e = a.e + b.e + 16'sd32;
      end else begin
        r.m = p[62:31];
        r.e = a.e + b.e + 16'sd31;
      end
    end
    return r;
  endfunction

  // truncate to signed Q32.32 with the given sign, saturating
  function automatic logic [63:0] pgf_tofix(xnum_t v, logic neg);
    logic signed [16:0] sh;
    logic [63:0]        mag;
    logic [63:0]        res;
    logic [5:0]         amt;
    sh  = 17'(v.e) + 17'sd32;
    mag = '0;
    amt = '0;
    if (v.m != '0 && sh >= 17'sd32) begin
      res = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      if (v.m == '0) begin
        mag = '0;
      end else if (sh >= 17'sd0) begin
        mag = {32'b0, v.m} << sh[4:0];
      end else if (sh > -17'sd64) begin
        amt = 6'(-sh);
        mag = {32'b0, v.m} >> amt;
      end
      res = neg ? (~mag + 64'd1) : mag;
    end
    return res;
  endfunction

endpackage

### src/pgf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgf_front
// Six-stage front end: separation per axis, exact r^2 from split squares,
// leading-one search and truncation of r^2, axis magnitudes and masses.
// ----------------------------------------------------------------------------
module pgf_front (
  input  logic           clk_i,
  input  logic           en_i,
  input  pgf_pkg::in_t   item_i,
  output pgf_pkg::front_t front_o
);
  import pgf_pkg::*;

  logic [47:0] mag1_q [3];
  logic [2:0]  neg1_q;
  logic [47:0] ma1_q, mb1_q;

  logic [47:0] hh2_q [3];
  logic [48:0] hl2_q [3];
  logic [47:0] ll2_q [3];
  logic [47:0] mag2_q [3];
  logic [6:0]  mpos2_q [3];
  logic [2:0]  neg2_q;
  logic [47:0] ma2_q, mb2_q;
  logic [6:0]  pa2_q, pb2_q;

  logic [95:0] sq3_q [3];
  front_t      f3_q;
  logic [97:0] s4_q;
  front_t      f4_q;
  logic [97:0] s5_q;
  logic [6:0]  pos5_q;
  front_t      f5_q;
  front_t      f6_q;

  logic [47:0] pa [3];
  logic [47:0] pb [3];

  assign pa[0] = item_i.first_x;
  assign pa[1] = item_i.first_y;
  assign pa[2] = item_i.first_z;
  assign pb[0] = item_i.second_x;
  assign pb[1] = item_i.second_y;
  assign pb[2] = item_i.second_z;

  // separation, magnitude and sign per axis
  always_ff @(posedge clk_i) begin
    logic [48:0] d;
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        d = {pa[i][47], pa[i]} - {pb[i][47], pb[i]};
        neg1_q[i] <= d[48];
        mag1_q[i] <= d[48] ? 48'(-d) : d[47:0];
      end
      ma1_q <= item_i.first_mass;
      mb1_q <= item_i.second_mass;
    end
  end

  // partial products of the squares; leading ones of magnitudes and masses
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        hh2_q[i]   <= mag1_q[i][47:24] * mag1_q[i][47:24];
        hl2_q[i]   <= 49'(mag1_q[i][47:24] * mag1_q[i][23:0]);
        ll2_q[i]   <= mag1_q[i][23:0] * mag1_q[i][23:0];
        mag2_q[i]  <= mag1_q[i];
        mpos2_q[i] <= pgf_msb({50'b0, mag1_q[i]});
      end
      neg2_q <= neg1_q;
      ma2_q  <= ma1_q;
      mb2_q  <= mb1_q;
      pa2_q  <= pgf_msb({50'b0, ma1_q});
      pb2_q  <= pgf_msb({50'b0, mb1_q});
    end
  end

  // square per axis; normalise magnitudes and masses
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq3_q[i]     <= ({48'b0, hh2_q[i]} << 48) + ({47'b0, hl2_q[i]} << 25)
                        + {48'b0, ll2_q[i]};
        f3_q.magn[i] <= pgf_norm({50'b0, mag2_q[i]}, mpos2_q[i], -16'sd32);
      end
      f3_q.dneg <= neg2_q;
      f3_q.m1n  <= pgf_norm({50'b0, ma2_q}, pa2_q, -16'sd47);
      f3_q.m2n  <= pgf_norm({50'b0, mb2_q}, pb2_q, -16'sd47);
      f3_q.s    <= '0;
    end
  end

  // exact r^2
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_q <= {2'b0, sq3_q[0]} + {2'b0, sq3_q[1]} + {2'b0, sq3_q[2]};
      f4_q <= f3_q;
    end
  end

  // find the leading one of r^2
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_q   <= s4_q;
      pos5_q <= pgf_msb(s4_q);
      f5_q   <= f4_q;
    end
  end

  // truncate r^2 to mantissa form
  always_ff @(posedge clk_i) begin
    front_t f;
    if (en_i) begin
      f    = f5_q;
      f.s  = pgf_norm(s5_q, pos5_q, -16'sd64);
      f6_q <= f;
    end
  end

  assign front_o = f6_q;

endmodule

### src/pgf_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgf_sqrt
// Pipelined digit-by-digit square root of a mantissa value, four result bits
// per stage. The result mantissa comes out already normalised.
// ----------------------------------------------------------------------------
module pgf_sqrt (
  input  logic          clk_i,
  input  logic          en_i,
  input  pgf_pkg::xnum_t s_i,
  output pgf_pkg::xnum_t r_o
);
  import pgf_pkg::*;

  typedef struct packed {
    logic [63:0] v;
    logic [34:0] rem;
    logic [31:0] q;
    pgf_exp_t    e;
  } sq_t;

  sq_t st_q [SqrtStages];
  sq_t st_d [SqrtStages];
  sq_t init;

  function automatic sq_t sq_step(sq_t a);
    sq_t         b;
    logic [34:0] r;
    logic [34:0] t;
    b = a;
    r = {a.rem[32:0], a.v[63:62]};
    t = {1'b0, a.q, 2'b01};
    b.v = a.v << 2;
    if (r >= t) begin
      b.rem = r - t;
      b.q   = {a.q[30:0], 1'b1};
    end else begin
      b.rem = r;
      b.q   = {a.q[30:0], 1'b0};
    end
    return b;
  endfunction

  // align the radicand to an even exponent
  always_comb begin
    pgf_exp_t eo;
    init     = '0;
    eo       = s_i.e - (s_i.e[0] ? 16'sd31 : 16'sd32);
    init.v   = s_i.e[0] ? {1'b0, s_i.m, 31'b0} : {s_i.m, 32'b0};
    init.e   = eo >>> 1;
  end

  for (genvar k = 0; k < SqrtStages; k++) begin : g_stage
    // resolve the next group of root bits
    always_comb begin
      sq_t c;
      c = (k == 0) ? init : st_q[(k == 0) ? 0 : k - 1];
      for (int j = 0; j < SqrtSteps; j++) c = sq_step(c);
      st_d[k] = c;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) st_q[k] <= st_d[k];
    end
  end

  assign r_o.m = st_q[SqrtStages-1].q;
  assign r_o.e = st_q[SqrtStages-1].e;

endmodule

### src/pgf_pow.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgf_pow
// r^(-beta) as 2^(-beta*log2 r): log2 by one squaring per stage, one stage
// for the scale by beta, then one root-of-two multiply per stage.
// ----------------------------------------------------------------------------
module pgf_pow (
  input  logic           clk_i,
  input  logic           en_i,
  input  pgf_pkg::xnum_t r_i,
  input  logic [15:0]    beta_i,
  output pgf_pkg::xnum_t rf_o
);
  import pgf_pkg::*;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] frac;
    pgf_exp_t    e;
  } lg_t;

  typedef struct packed {
    logic [31:0] y;
    logic [31:0] fr;
    pgf_exp_t    ip;
  } pw_t;

  lg_t lg_q [LogStages];
  lg_t lg_d [LogStages];
  pw_t pw_q [PowStages];
  pw_t pw_d [PowStages];
  pw_t u_q;

  for (genvar k = 0; k < LogStages; k++) begin : g_log
    // square and pull out one fraction bit
    always_comb begin
      lg_t         c;
      logic [63:0] p;
      c = (k == 0) ? lg_t'{x: r_i.m, frac: 32'b0, e: r_i.e} : lg_q[(k == 0) ? 0 : k - 1];
      p = 64'(c.x) * 64'(c.x);
      if (p[63]) begin
        c.x = p[63:32];
        c.frac[31-k] = 1'b1;
      end else begin
        c.x = p[62:31];
      end
      lg_d[k] = c;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) lg_q[k] <= lg_d[k];
    end
  end

  // scale log2 r by -beta; split into integer and fraction
  always_ff @(posedge clk_i) begin
    logic signed [48:0] lg;
    logic signed [65:0] u;
    lg = {17'(lg_q[LogStages-1].e) + 17'sd31, lg_q[LogStages-1].frac};
    u  = -(66'(lg) * 66'(signed'({1'b0, beta_i})));
    if (en_i) begin
      u_q.y  <= 32'h8000_0000;
      u_q.fr <= u[45:14];
      u_q.ip <= u[61:46];
    end
  end

  for (genvar k = 0; k < PowStages; k++) begin : g_pow
    localparam logic [31:0] Root = pgf_root(k + 1);
    // multiply in the root for this fraction bit
    always_comb begin
      pw_t         c;
      logic [63:0] p;
      c = (k == 0) ? u_q : pw_q[(k == 0) ? 0 : k - 1];
      p = 64'(c.y) * 64'(Root);
      if (c.fr[31-k]) c.y = p[62:31];
      pw_d[k] = c;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) pw_q[k] <= pw_d[k];
    end
  end

  assign rf_o.m = pw_q[PowStages-1].y;
  assign rf_o.e = pw_q[PowStages-1].ip - 16'sd31;

endmodule

### src/pgf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgf_div
// Pipelined restoring divider for mantissa values: 33 quotient bits, three
// per stage, then a one-bit normalisation.
// ----------------------------------------------------------------------------
module pgf_div (
  input  logic           clk_i,
  input  logic           en_i,
  input  pgf_pkg::xnum_t a_i,
  input  pgf_pkg::xnum_t b_i,
  output pgf_pkg::xnum_t q_o
);
  import pgf_pkg::*;

  typedef struct packed {
    logic [31:0] rem;
    logic [32:0] q;
    logic [31:0] b;
    logic        a0;
    pgf_exp_t    e;
    logic        zero;
  } dv_t;

  dv_t st_q [DivStages];
  dv_t st_d [DivStages];
  dv_t init;
  dv_t last;

  always_comb begin
    init      = '0;
    init.rem  = {1'b0, a_i.m[31:1]};
    init.b    = b_i.m;
    init.a0   = a_i.m[0];
    init.e    = a_i.e - b_i.e - 16'sd32;
    init.zero = (a_i.m == '0) || (b_i.m == '0);
  end

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    // compare and subtract, one quotient bit a step
    always_comb begin
      dv_t         c;
      logic [32:0] r2;
      c = (k == 0) ? init : st_q[(k == 0) ? 0 : k - 1];
      for (int j = 0; j < DivSteps; j++) begin
        r2 = {c.rem, (k == 0 && j == 0) ? c.a0 : 1'b0};
        if (r2 >= {1'b0, c.b}) begin
          r2  = r2 - {1'b0, c.b};
          c.q = {c.q[31:0], 1'b1};
        end else begin
          c.q = {c.q[31:0], 1'b0};
        end
        c.rem = r2[31:0];
      end
      st_d[k] = c;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) st_q[k] <= st_d[k];
    end
  end

  // drop the extra quotient bit when present
  always_comb begin
    last = st_q[DivStages-1];
    q_o  = '0;
    if (!last.zero) begin
      if (last.q[32]) begin
        q_o.m = last.q[32:1];
        q_o.e = last.e + 16'sd1;
      end else begin
        q_o.m = last.q[31:0];
        q_o.e = last.e;
      end
    end
  end

endmodule

### src/pairwise_gravity_force_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_gravity_force_top
// Gravitational force and potential between two bodies, fixed point.
// ----------------------------------------------------------------------------
// One body pair enters per clock while the pipeline advances; the
// pipeline stalls as a whole while a finished result waits on the output.
// The depth is set mostly by r^(-beta): 32 squaring stages for log2 r and 32
// root-multiply stages for the power of two, each one 32x32 multiply, after
// six front-end stages and eight square-root stages; the dividers take 11.
// Write exponent_beta only while the pipeline is empty.
// ----------------------------------------------------------------------------
module pairwise_gravity_force_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,    // exponent_beta
  // input items
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // first_x, first_y, first_z, first_mass, second_x, second_y, second_z,
  // second_mass (48 bits each, from bit 0 up)
  input  logic [383:0] s_axis_tdata_i,
  // result items
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // first_force_x, first_force_y, first_force_z, second_force_x,
  // second_force_y, second_force_z, potential (64 bits each, from bit 0 up)
  output logic [447:0] m_axis_tdata_o,
  output logic [0:0]   m_axis_tuser_o  // coincident
);
  import pgf_pkg::*;

  // stage numbers at which values become available
  localparam int unsigned TR      = LatFront + SqrtStages;
  localparam int unsigned TRf     = TR + LatPow;
  localparam int unsigned TK      = TRf + 3;
  localparam int unsigned TKm     = TK + 1;
  localparam int unsigned TPotDiv = TK + DivStages;
  localparam int unsigned TF      = TKm + DivStages;
  localparam int unsigned TOut    = TF + 1;

  localparam int unsigned SideDepth = TF - LatFront;
  localparam int unsigned RDepth    = TK - TR;
  localparam int unsigned R3Depth   = TKm - TR - 2;
  localparam int unsigned RfDepth   = TPotDiv - TRf;

  localparam logic [63:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinNeg = 64'h8000_0000_0000_0000;

  logic        adv;
  logic [15:0] beta_q;
  logic        vld_q [TOut];

  front_t front;
  xnum_t  r, rf, divpot, divf [3];

  front_t side_q [SideDepth];
  xnum_t  rd_q   [RDepth];
  xnum_t  r3d_q  [R3Depth];
  xnum_t  rfd_q  [RfDepth];
  xnum_t  r2_q, r3_q, k1_q, k2_q, k_q, pot_q;
  xnum_t  km_q [3];

  logic [63:0] ff_q [3];
  logic [63:0] sf_q [3];
  logic [63:0] pot_fix_q;
  logic        coinc_q;
  front_t      side_out;

  // the whole pipe advances unless a result is held on the output
  assign adv             = !vld_q[TOut-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // configuration register and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= '0;
      for (int n = 0; n < TOut; n++) vld_q[n] <= 1'b0;
    end else begin
      if (cfg_we_i) beta_q <= cfg_wdata_i;
      if (adv) begin
        vld_q[0] <= s_axis_tvalid_i;
        for (int n = 1; n < TOut; n++) vld_q[n] <= vld_q[n-1];
      end
    end
  end

  pgf_front u_front (
    .clk_i   (clk_i),
    .en_i    (adv),
    .item_i  (in_t'(s_axis_tdata_i)),
    .front_o (front)
  );

  pgf_sqrt u_sqrt (
    .clk_i (clk_i),
    .en_i  (adv),
    .s_i   (front.s),
    .r_o   (r)
  );

  pgf_pow u_pow (
    .clk_i  (clk_i),
    .en_i   (adv),
    .r_i    (r),
    .beta_i (beta_q),
    .rf_o   (rf)
  );

  // potential: k / r
  pgf_div u_div_pot (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (k_q),
    .b_i   (rd_q[TK-TR-1]),
    .q_o   (divpot)
  );

  // forces: k * |d| / r^3 per axis
  for (genvar i = 0; i < 3; i++) begin : g_axis
    pgf_div u_div_f (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (km_q[i]),
      .b_i   (r3d_q[TKm-TR-3]),
      .q_o   (divf[i])
    );
  end

  // delay lines and the product chain
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= front;
      for (int n = 1; n < SideDepth; n++) side_q[n] <= side_q[n-1];
      rd_q[0] <= r;
      for (int n = 1; n < RDepth; n++) rd_q[n] <= rd_q[n-1];
      r3d_q[0] <= r3_q;
      for (int n = 1; n < R3Depth; n++) r3d_q[n] <= r3d_q[n-1];
      rfd_q[0] <= rf;
      for (int n = 1; n < RfDepth; n++) rfd_q[n] <= rfd_q[n-1];

      r2_q <= pgf_mul(r, r);
      r3_q <= pgf_mul(r2_q, rd_q[0]);

      k1_q <= pgf_mul(rf, FourPiSq);
      k2_q <= pgf_mul(k1_q, side_q[TRf-LatFront].m1n);
      k_q  <= pgf_mul(k2_q, side_q[TRf+1-LatFront].m2n);
      for (int i = 0; i < 3; i++) begin
        km_q[i] <= pgf_mul(k_q, side_q[TK-LatFront-1].magn[i]);
      end
      pot_q <= pgf_mul(divpot, rfd_q[TPotDiv-TRf-1]);
    end
  end

  assign side_out = side_q[TF-LatFront-1];

  // convert to fixed point; clear everything for coincident bodies
  always_ff @(posedge clk_i) begin
    if (adv) begin
      coinc_q <= (side_out.s.m == '0);
      for (int i = 0; i < 3; i++) begin
        ff_q[i] <= (side_out.s.m == '0) ? '0 : pgf_tofix(divf[i], !side_out.dneg[i]);
        sf_q[i] <= (side_out.s.m == '0) ? '0 : pgf_tofix(divf[i], side_out.dneg[i]);
      end
      pot_fix_q <= (side_out.s.m == '0) ? '0 : pgf_tofix(pot_q, 1'b1);
    end
  end

  assign m_axis_tvalid_o = vld_q[TOut-1];
  assign m_axis_tdata_o  = {pot_fix_q, sf_q[2], sf_q[1], sf_q[0], ff_q[2], ff_q[1], ff_q[0]};
  assign m_axis_tuser_o  = coinc_q;

  // coincident bodies give all-zero results
  a_coinc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && coinc_q |-> m_axis_tdata_o == '0)
    else $error("coincident result not zero");

  // x and z forces on the two bodies are opposite, up to saturation
  a_force_x_opp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((ff_q[0] + sf_q[0]) == 64'd0) ||
      (ff_q[0] == MaxPos && sf_q[0] == MinNeg) || (ff_q[0] == MinNeg && sf_q[0] == MaxPos))
    else $error("x forces not opposite");

  a_force_z_opp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((ff_q[2] + sf_q[2]) == 64'd0) ||
      (ff_q[2] == MaxPos && sf_q[2] == MinNeg) || (ff_q[2] == MinNeg && sf_q[2] == MaxPos))
    else $error("z forces not opposite");

  // the potential is never positive
  a_pot_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pot_fix_q[63] || pot_fix_q == '0)
    else $error("positive potential");

endmodule

### test/tb_pairwise_gravity_force_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pairwise_gravity_force_top
// Stream test of the pairwise gravity force block. The test drives a short
// table of body pairs, then random pairs, under several exponent settings.
// Each result is checked field by field against a model in this file or
// a stored table result. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module tb_pairwise_gravity_force_top;
  import pgf_pkg::*;

  localparam int unsigned WatchLimit = 4000;
  localparam int unsigned DrainWait  = 120;
  localparam int unsigned PhaseItems = 205;

  typedef struct {
    logic [31:0] m;
    int          e;
  } fnum_t;

  typedef struct {
    logic [447:0] forces;
    logic         coinc;
  } force_res_t;

  typedef struct {
    in_t          pair;
    logic         known;
    logic [447:0] forces;
    logic         coinc;
  } pair_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [15:0]  cfg_wdata_i;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [383:0] s_axis_tdata_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [447:0] m_axis_tdata_o;
  logic [0:0]   m_axis_tuser_o;

  force_res_t   force_q[$];
  pair_row_t    pair_table[13];
  logic [15:0]  beta_now;
  int unsigned  fail_count;
  int unsigned  idle_cycles;

  pairwise_gravity_force_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // normalise a value times 2^e to a 32-bit mantissa, truncating
  function automatic fnum_t fnorm(logic [63:0] v, int e);
    fnum_t r;
    r.m = '0;
    r.e = 0;
    if (v == '0) return r;
    while (v >= 64'h1_0000_0000) begin
      v = v >> 1;
      e++;
    end
    while (v < 64'h8000_0000) begin
      v = v << 1;
      e--;
    end
    r.m = v[31:0];
    r.e = e;
    return r;
  endfunction

  function automatic fnum_t fmul(fnum_t a, fnum_t b);
    fnum_t z;
    z.m = '0;
    z.e = 0;
    if (a.m == '0 || b.m == '0) return z;
    return fnorm(64'(a.m) * 64'(b.m), a.e + b.e);
  endfunction

  function automatic fnum_t fdiv(fnum_t a, fnum_t b);
    fnum_t z;
    z.m = '0;
    z.e = 0;
    if (a.m == '0 || b.m == '0) return z;
    return fnorm((64'(a.m) << 32) / 64'(b.m), a.e - b.e - 32);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != '0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic fnum_t fsqrt(fnum_t a);
    fnum_t z;
    z.m = '0;
    z.e = 0;
    if (a.m == '0) return z;
    if (a.e[0] == 1'b0) return fnorm(floor_sqrt(64'(a.m) << 32), (a.e - 32) / 2);
    return fnorm(floor_sqrt(64'(a.m) << 31), (a.e - 31) / 2);
  endfunction

  // r^(-beta) as 2^(-beta * log2 r), for r nonzero
  function automatic fnum_t range_power(fnum_t r, logic [15:0] beta);
    logic [63:0] x;
    logic [63:0] frac;
    logic [63:0] fr;
    logic [63:0] y;
    logic [63:0] c;
    longint      lg;
    longint      u;
    longint      unit;
    int          ip;
    x    = 64'(r.m);
    frac = '0;
    y    = 64'h8000_0000;
    c    = 64'h1_0000_0000;
    unit = longint'(1) << 46;
    for (int i = 1; i <= 32; i++) begin
      x = (x * x) >> 31;
      if (x >= 64'h1_0000_0000) begin
        x    = x >> 1;
        frac = frac | (64'd1 << (32 - i));
      end
    end
    lg = longint'(r.e + 31) * 64'sd4294967296 + longint'(frac);
    u  = -(lg * longint'({48'b0, beta}));
    if (u >= 0) ip = int'(u / unit);
    else ip = -int'((-u + unit - 1) / unit);
    fr = 64'(u - longint'(ip) * unit);
    for (int i = 1; i <= 32; i++) begin
      c = floor_sqrt(c << 31);
      if (fr[46 - i]) y = (y * c) >> 31;
    end
    return fnorm(y, ip - 31);
  endfunction

  function automatic logic [63:0] to_q32(fnum_t v, logic neg);
    int          sh;
    logic [63:0] mag;
    sh = v.e + 32;
    if (v.m == '0) return '0;
    if (sh >= 32) return neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (sh >= 0) mag = 64'(v.m) << sh;
    else if (sh <= -64) mag = '0;
    else mag = 64'(v.m) >> (-sh);
    return neg ? (~mag + 64'd1) : mag;
  endfunction

  // forces and potential of one body pair
  function automatic force_res_t predict_force(in_t p, logic [15:0] beta);
    force_res_t   res;
    logic [47:0]  pa[3];
    logic [47:0]  pb[3];
    logic [63:0]  mag[3];
    logic         dneg[3];
    logic [127:0] sq;
    longint       d;
    int           e;
    fnum_t        s, r, r3, rf, k, pot, f, four_pi;
    pa = '{p.first_x, p.first_y, p.first_z};
    pb = '{p.second_x, p.second_y, p.second_z};
    sq = '0;
    res.forces = '0;
    res.coinc  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      d       = longint'($signed(pa[i])) - longint'($signed(pb[i]));
      dneg[i] = d < 0;
      mag[i]  = dneg[i] ? 64'(-d) : 64'(d);
      sq      = sq + 128'(mag[i]) * 128'(mag[i]);
    end
    if (sq == '0) begin
      res.coinc = 1'b1;
      return res;
    end
    e = -64;
    while (sq[127:64] != '0) begin
      sq = sq >> 1;
      e++;
    end
    four_pi.m = 32'd2649351758;
    four_pi.e = -26;
    s   = fnorm(sq[63:0], e);
    r   = fsqrt(s);
    r3  = fmul(fmul(r, r), r);
    rf  = range_power(r, beta);
    k   = fmul(fmul(fmul(rf, four_pi), fnorm(64'(p.first_mass), -47)),
               fnorm(64'(p.second_mass), -47));
    pot = fmul(fdiv(k, r), rf);
    for (int i = 0; i < 3; i++) begin
      f = fdiv(fmul(k, fnorm(mag[i], -32)), r3);
      res.forces[64*i +: 64]       = to_q32(f, !dneg[i]);
      res.forces[64*(3 + i) +: 64] = to_q32(f, dneg[i]);
    end
    res.forces[6*64 +: 64] = to_q32(pot, 1'b1);
    return res;
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // position offset with a random reach, from one LSB up to the full range
  function automatic logic [47:0] rand_offset();
    logic signed [63:0] off;
    off = $signed({$urandom, $urandom});
    return 48'(off >>> $urandom_range(16, 63));
  endfunction

  function automatic logic [47:0] rand_mass();
    case ($urandom_range(0, 3))
      0: return rand48();
      1: return rand48() >> $urandom_range(1, 47);
      2: return 48'h8000_0000_0000;
      default: return rand48() | 48'h8000_0000_0000;
    endcase
  endfunction

  // mostly nearby pairs with random content, some wide and coincident ones
  function automatic in_t rand_pair();
    in_t p;
    p.first_x     = rand48();
    p.first_y     = rand48();
    p.first_z     = rand48();
    p.first_mass  = rand_mass();
    p.second_mass = rand_mass();
    case ($urandom_range(0, 15))
      0, 1, 2: begin
        p.second_x = rand48();
        p.second_y = rand48();
        p.second_z = rand48();
      end
      3: begin
        p.second_x = p.first_x;
        p.second_y = p.first_y;
        p.second_z = p.first_z;
      end
      default: begin
        p.second_x = p.first_x - rand_offset();
        p.second_y = p.first_y - rand_offset();
        p.second_z = p.first_z - rand_offset();
      end
    endcase
    return p;
  endfunction

  function automatic pair_row_t make_row(logic [47:0] ax, logic [47:0] ay, logic [47:0] az,
                                         logic [47:0] am, logic [47:0] bx, logic [47:0] by,
                                         logic [47:0] bz, logic [47:0] bm,
                                         logic known, logic coinc);
    pair_row_t row;
    row.pair   = '{second_mass: bm, second_z: bz, second_y: by, second_x: bx,
                   first_mass: am, first_z: az, first_y: ay, first_x: ax};
    row.known  = known;
    row.forces = '0;
    row.coinc  = coinc;
    return row;
  endfunction

  task automatic build_table();
    logic [47:0] au, mx, pmax, pmin, one;
    au   = 48'h1_0000_0000;
    mx   = 48'hFFFF_FFFF_FFFF;
    one  = 48'h8000_0000_0000;
    pmax = 48'h7FFF_FFFF_FFFF;
    pmin = 48'h8000_0000_0000;
    // zeroed results: coincident bodies and zero masses
    pair_table[0]  = make_row(0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1);
    pair_table[1]  = make_row(pmax, pmin, au, mx, pmax, pmin, au, mx, 1'b1, 1'b1);
    pair_table[2]  = make_row(au, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0);
    pair_table[3]  = make_row(au, au, 0, 0, 0, 0, 0, mx, 1'b1, 1'b0);
    // unit distances along each axis, and a diagonal in the other direction
    pair_table[4]  = make_row(au, 0, 0, mx, 0, 0, 0, mx, 1'b0, 1'b0);
    pair_table[5]  = make_row(0, au, 0, one, 0, 0, 0, one, 1'b0, 1'b0);
    pair_table[6]  = make_row(0, 0, au, one, 0, 0, 0, one, 1'b0, 1'b0);
    pair_table[7]  = make_row(0, 0, 0, one, au, au, au, one, 1'b0, 1'b0);
    // widest separations
    pair_table[8]  = make_row(pmax, pmax, pmax, mx, pmin, pmin, pmin, mx, 1'b0, 1'b0);
    pair_table[9]  = make_row(pmin, pmin, pmin, mx, pmax, pmax, pmax, mx, 1'b0, 1'b0);
    // one LSB apart, force saturates
    pair_table[10] = make_row(1, 0, 0, mx, 0, 0, 0, mx, 1'b0, 1'b0);
    pair_table[11] = make_row(0, 0, 0, mx, 1, 1, 1, mx, 1'b0, 1'b0);
    // sun and a light planet
    pair_table[12] = make_row(au, 0, 0, one, 0, 0, 0, 48'd422212465, 1'b0, 1'b0);
  endtask

  // offer one pair and hold it until it is taken
  task automatic send_pair(in_t p, logic known, force_res_t fixed);
    int unsigned gap;
    logic        took;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= p;
    forever begin
      @(negedge clk_i);
      took = s_axis_tready_o;
      @(posedge clk_i);
      if (took) break;
    end
    force_q.push_back(known ? fixed : predict_force(p, beta_now));
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (force_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_beta(logic [15:0] b);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    beta_now = b;
  endtask

  // take results with random stalls and check them
  initial begin
    int unsigned stall;
    force_res_t  exp_res;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      forever begin
        @(negedge clk_i);
        if (m_axis_tvalid_o && m_axis_tready_i) begin
          if (force_q.size() == 0) begin
            $display("%0t: unexpected result %h coinc %b", $time, m_axis_tdata_o,
                     m_axis_tuser_o);
            fail_count++;
          end else begin
            exp_res = force_q.pop_front();
            for (int i = 0; i < 7; i++) begin
              if (m_axis_tdata_o[64*i +: 64] !== exp_res.forces[64*i +: 64]) begin
                $display("%0t: field %0d expected %h actual %h", $time, i,
                         exp_res.forces[64*i +: 64], m_axis_tdata_o[64*i +: 64]);
                fail_count++;
              end
            end
            if (m_axis_tuser_o[0] !== exp_res.coinc) begin
              $display("%0t: coincident expected %b actual %b", $time, exp_res.coinc,
                       m_axis_tuser_o[0]);
              fail_count++;
            end
          end
          @(posedge clk_i);
          break;
        end
        @(posedge clk_i);
      end
    end
  end

  // stop the run if the stream stops moving
  always @(negedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] beta_set[7];
    force_res_t  fixed;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    beta_now        = '0;
    beta_set = '{16'd0, 16'hFFFF, 16'd16384, 16'd1, 16'd8192,
                 16'($urandom), 16'd32768};
    build_table();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the table at the reset exponent
    foreach (pair_table[i]) begin
      fixed.forces = pair_table[i].forces;
      fixed.coinc  = pair_table[i].coinc;
      send_pair(pair_table[i].pair, pair_table[i].known, fixed);
    end

    // random pairs under each exponent setting
    foreach (beta_set[ph]) begin
      wait_idle();
      write_beta(beta_set[ph]);
      for (int n = 0; n < PhaseItems; n++) begin
        send_pair(rand_pair(), 1'b0, fixed);
      end
    end

    wait_idle();
    if (fail_count == 0 && force_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### pairwise_gravity_force_top.f
src/pgf_pkg.sv
src/pgf_front.sv
src/pgf_sqrt.sv
src/pgf_pow.sv
src/pgf_div.sv
src/pairwise_gravity_force_top.sv
test/tb_pairwise_gravity_force_top.sv
